// ----- rtl/rkga_pkg.sv -----
`default_nettype none

package rkga_pkg;

    localparam int unsigned KNOBS  = 3;
    localparam int unsigned STEP_W = 10;
    localparam int unsigned SEL_W  = 2;
    localparam int unsigned OUT_W  = 32;

    typedef logic [SEL_W-1:0]  t_step_sel;
    typedef logic [STEP_W-1:0] t_step_size;

    // step size for each selection code
    localparam t_step_size STEP_SIZE [4] = '{
        STEP_W'(1), STEP_W'(10), STEP_W'(100), STEP_W'(1000)
    };

    // shared control for the per-knob update
    typedef struct packed {
        logic en;      // item moves into the result register this cycle
        logic primed;  // not the first item since reset
    } t_knob_ctl;

endpackage

`default_nettype wire

// ----- rtl/rotary_knob_gain_adjuster.sv -----
// An accepted input goes into the input register, then moves into the result register, where it is valid.
// One item per cycle while the result is taken; the per-knob compare and one add/subtract set the path.
// The input register keeps taking items while a result waits, until both stages are full.
// Reset (i_rst_n, synchronous, active low): gains and step selections zero, switch levels
// released, stages empty; the first item after reset only records knob levels.
`default_nettype none

module rotary_knob_gain_adjuster #(
    parameter int unsigned GAIN_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_clk_p,
    input  wire logic        i_dt_p,
    input  wire logic        i_sw_p,
    input  wire logic        i_clk_d,
    input  wire logic        i_dt_d,
    input  wire logic        i_sw_d,
    input  wire logic        i_clk_i,
    input  wire logic        i_dt_i,
    input  wire logic        i_sw_i,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_gain_p_out,
    output logic [31:0]      o_gain_d_out,
    output logic [31:0]      o_gain_i_out,
    output logic [1:0]       o_step_p_out,
    output logic [1:0]       o_step_d_out,
    output logic [1:0]       o_step_i_out
);

    localparam int unsigned K = rkga_pkg::KNOBS;

    logic               r_in_vld;
    logic [K-1:0]       r_clk_lvl, r_dt, r_sw;
    logic               r_primed;
    logic               r_out_vld;
    logic               advance;
    rkga_pkg::t_knob_ctl ctl;

    logic [GAIN_WIDTH-1:0]      gain_nxt [K];
    rkga_pkg::t_step_sel        step_nxt [K];
    logic [rkga_pkg::OUT_W-1:0] r_gain_out [K];
    rkga_pkg::t_step_sel        r_step_out [K];

    assign advance = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || advance;

    assign ctl.en     = advance;
    assign ctl.primed = r_primed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_primed  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_primed  <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // knob order: proportional, derivative, integral
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_clk_lvl <= {i_clk_i, i_clk_d, i_clk_p};
            r_dt      <= {i_dt_i, i_dt_d, i_dt_p};
            r_sw      <= {i_sw_i, i_sw_d, i_sw_p};
        end
    end

    for (genvar k = 0; k < K; k++) begin : g_knob
        rkga_knob #(
            .GAIN_WIDTH (GAIN_WIDTH)
        ) u_knob (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_clk_lvl (r_clk_lvl[k]),
            .i_dt      (r_dt[k]),
            .i_sw      (r_sw[k]),
            .o_gain    (gain_nxt[k]),
            .o_step    (step_nxt[k])
        );

        always_ff @(posedge i_clk) begin
            if (advance) begin
                r_gain_out[k] <= rkga_pkg::OUT_W'(gain_nxt[k]);
                r_step_out[k] <= step_nxt[k];
            end
        end
    end

    assign o_valid      = r_out_vld;
    assign o_gain_p_out = r_gain_out[0];
    assign o_gain_d_out = r_gain_out[1];
    assign o_gain_i_out = r_gain_out[2];
    assign o_step_p_out = r_step_out[0];
    assign o_step_d_out = r_step_out[1];
    assign o_step_i_out = r_step_out[2];

endmodule

`default_nettype wire

// ----- rtl/rkga_knob.sv -----
`default_nettype none

module rkga_knob #(
    parameter int unsigned GAIN_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire rkga_pkg::t_knob_ctl   i_ctl,
    input  wire logic                  i_clk_lvl,
    input  wire logic                  i_dt,
    input  wire logic                  i_sw,
    output logic [GAIN_WIDTH-1:0]      o_gain,
    output rkga_pkg::t_step_sel        o_step
);

    logic [GAIN_WIDTH-1:0] r_gain, n_gain;
    rkga_pkg::t_step_sel   r_step, n_step;
    logic                  r_last_clk;
    logic                  r_last_sw;
    logic [GAIN_WIDTH-1:0] step_amt;

    // 1000 wraps like everything else when the gain is narrow
    assign step_amt = GAIN_WIDTH'(rkga_pkg::STEP_SIZE[r_step]);

    always_comb begin
        n_gain = r_gain;
        n_step = r_step;
        if (i_ctl.primed) begin
            if (i_clk_lvl != r_last_clk) begin
                if (i_dt != i_clk_lvl) begin
                    n_gain = r_gain + step_amt;
                end else begin
                    n_gain = r_gain - step_amt;
                end
            end
            // release: low before, high now
            if (!r_last_sw && i_sw) begin
                n_step = r_step + rkga_pkg::SEL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= '0;
            r_step     <= '0;
            r_last_clk <= 1'b0;
            r_last_sw  <= 1'b1;
        end else if (i_ctl.en) begin
            r_gain     <= n_gain;
            r_step     <= n_step;
            r_last_clk <= i_clk_lvl;
            r_last_sw  <= i_sw;
        end
    end

    assign o_gain = n_gain;
    assign o_step = n_step;

endmodule

`default_nettype wire

// ----- verif/tb_rotary_knob_gain_adjuster.sv -----
`default_nettype none

typedef enum int {KNOB_P, KNOB_D, KNOB_I} knob_e;

typedef enum logic [1:0] {
    SEL_ONE      = 2'd0,
    SEL_TEN      = 2'd1,
    SEL_HUNDRED  = 2'd2,
    SEL_THOUSAND = 2'd3
} step_sel_e;

// bit index within each vector is the knob (knob_e)
typedef struct packed {
    logic [2:0] clk;
    logic [2:0] dt;
    logic [2:0] sw;
} knob_pins_t;

typedef struct packed {
    logic [2:0][31:0] gain;
    logic [2:0][1:0]  sel;
} knob_gains_t;

class gain_scoreboard;
    localparam int GAIN_W = 32;

    logic [GAIN_W-1:0] gain [3];
    logic [1:0]        sel [3];
    logic              last_clk [3];
    logic              last_sw [3];
    bit                primed;
    knob_gains_t       pending_gains [$];
    int                error_count;

    function new();
        for (int k = 0; k < 3; k++) begin
            gain[k]     = '0;
            sel[k]      = SEL_ONE;
            last_clk[k] = 1'b0;
            last_sw[k]  = 1'b1;
        end
        primed      = 1'b0;
        error_count = 0;
    endfunction

    function logic [GAIN_W-1:0] step_amount(logic [1:0] code);
        case (code)
            SEL_ONE:      return GAIN_W'(1);
            SEL_TEN:      return GAIN_W'(10);
            SEL_HUNDRED:  return GAIN_W'(100);
            default:      return GAIN_W'(1000);
        endcase
    endfunction

    // advance the knob state by one accepted sample and queue the gains it leaves
    function void note_sample(knob_pins_t pins);
        knob_gains_t nxt;
        for (int k = 0; k < 3; k++) begin
            if (primed) begin
                if (pins.clk[k] != last_clk[k]) begin
                    if (pins.dt[k] != pins.clk[k])
                        gain[k] = gain[k] + step_amount(sel[k]);
                    else
                        gain[k] = gain[k] - step_amount(sel[k]);
                end
                // turn uses the old selection, then a release advances it
                if (!last_sw[k] && pins.sw[k])
                    sel[k] = sel[k] + 2'd1;
            end
            last_clk[k] = pins.clk[k];
            last_sw[k]  = pins.sw[k];
        end
        primed = 1'b1;
        for (int k = 0; k < 3; k++) begin
            nxt.gain[k] = 32'(gain[k]);
            nxt.sel[k]  = sel[k];
        end
        pending_gains.push_back(nxt);
    endfunction

    function void check_result(knob_gains_t got);
        knob_gains_t exp_g;
        if (pending_gains.size() == 0) begin
            $display("%0t: result with nothing pending, gains %h %h %h", $time,
                     got.gain[KNOB_P], got.gain[KNOB_D], got.gain[KNOB_I]);
            error_count++;
            return;
        end
        exp_g = pending_gains.pop_front();
        for (int k = 0; k < 3; k++) begin
            if (got.gain[k] !== exp_g.gain[k]) begin
                $display("%0t: knob %0d gain expected %h actual %h", $time, k,
                         exp_g.gain[k], got.gain[k]);
                error_count++;
            end
            if (got.sel[k] !== exp_g.sel[k]) begin
                $display("%0t: knob %0d step expected %0d actual %0d", $time, k,
                         exp_g.sel[k], got.sel[k]);
                error_count++;
            end
        end
    endfunction

    function int pending_count();
        return pending_gains.size();
    endfunction
endclass

module tb_rotary_knob_gain_adjuster;

    localparam int RANDOM_SAMPLES = 1800;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AFTER     = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_ready = 1'b0;
    knob_pins_t  sample_q = '0;
    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_gain_p_out, o_gain_d_out, o_gain_i_out;
    logic [1:0]  o_step_p_out, o_step_d_out, o_step_i_out;

    gain_scoreboard sb = new();
    knob_pins_t     levels = '0;
    logic [2:0]     turn_up = '0;
    int             samples_accepted = 0;
    int             burst_left = 0;
    int             cycle_count = 0;

    rotary_knob_gain_adjuster u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_clk_p      (sample_q.clk[KNOB_P]),
        .i_dt_p       (sample_q.dt[KNOB_P]),
        .i_sw_p       (sample_q.sw[KNOB_P]),
        .i_clk_d      (sample_q.clk[KNOB_D]),
        .i_dt_d       (sample_q.dt[KNOB_D]),
        .i_sw_d       (sample_q.sw[KNOB_D]),
        .i_clk_i      (sample_q.clk[KNOB_I]),
        .i_dt_i       (sample_q.dt[KNOB_I]),
        .i_sw_i       (sample_q.sw[KNOB_I]),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_gain_p_out (o_gain_p_out),
        .o_gain_d_out (o_gain_d_out),
        .o_gain_i_out (o_gain_i_out),
        .o_step_p_out (o_step_p_out),
        .o_step_d_out (o_step_d_out),
        .o_step_i_out (o_step_i_out)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic knob_pins_t pins_of(logic [2:0] c, logic [2:0] d, logic [2:0] s);
        knob_pins_t p;
        p.clk = c;
        p.dt  = d;
        p.sw  = s;
        return p;
    endfunction

    // mostly clean knob turns and presses, some line noise
    function automatic knob_pins_t next_knob_sample();
        int roll;
        if ($urandom_range(99) < 8) begin
            levels = knob_pins_t'($urandom_range(511));
            return levels;
        end
        for (int k = 0; k < 3; k++) begin
            if ($urandom_range(99) < 10)
                turn_up[k] = ~turn_up[k];
            roll = $urandom_range(99);
            if (roll < 55 || (roll >= 75 && roll < 85)) begin
                levels.clk[k] = ~levels.clk[k];
                levels.dt[k]  = turn_up[k] ? ~levels.clk[k] : levels.clk[k];
            end else if (roll < 62) begin
                levels.dt[k] = ~levels.dt[k];  // bounce on DT alone
            end
            if (roll >= 62 && roll < 85)
                levels.sw[k] = ~levels.sw[k];
        end
        return levels;
    endfunction

    // called at an edge where the line is free; returns at the accepting edge
    task automatic send_sample(input knob_pins_t pins);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid  <= 1'b1;
        sample_q <= pins;
        do @(posedge i_clk); while (!o_ready);
        sb.note_sample(pins);
        samples_accepted++;
    endtask

    initial begin : receiver
        int stall_pct;
        int phase_left;
        bit held;
        stall_pct  = 0;
        phase_left = 0;
        held       = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && samples_accepted >= HOLD_AFTER) begin
                // long hold-off so the block fills and pushes back
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (phase_left == 0) begin
                    phase_left = $urandom_range(20, 80);
                    case ($urandom_range(3))
                        0:       stall_pct = 0;
                        1:       stall_pct = 25;
                        2:       stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                phase_left--;
                i_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        knob_gains_t got;
        if (i_rst_n && o_valid && i_ready) begin
            got.gain[KNOB_P] = o_gain_p_out;
            got.gain[KNOB_D] = o_gain_d_out;
            got.gain[KNOB_I] = o_gain_i_out;
            got.sel[KNOB_P]  = o_step_p_out;
            got.sel[KNOB_D]  = o_step_d_out;
            got.sel[KNOB_I]  = o_step_i_out;
            sb.check_result(got);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first sample: levels differ from reset but are only recorded
        send_sample(pins_of(3'b111, 3'b000, 3'b000));
        send_sample(pins_of(3'b111, 3'b000, 3'b111));  // release all
        send_sample(pins_of(3'b000, 3'b000, 3'b111));  // down through zero
        send_sample(pins_of(3'b111, 3'b000, 3'b111));  // back up across the wrap
        send_sample(pins_of(3'b110, 3'b111, 3'b011));
        send_sample(pins_of(3'b111, 3'b111, 3'b111));
        send_sample(pins_of(3'b011, 3'b000, 3'b000));
        // turn and release together on every knob
        send_sample(pins_of(3'b100, 3'b000, 3'b111));
        send_sample(pins_of(3'b011, 3'b011, 3'b000));
        send_sample(pins_of(3'b011, 3'b100, 3'b111));
        send_sample(pins_of(3'b100, 3'b100, 3'b111));
        send_sample(pins_of(3'b011, 3'b000, 3'b111));
        send_sample(pins_of(3'b011, 3'b000, 3'b010));
        send_sample(pins_of(3'b100, 3'b111, 3'b111));
        send_sample(pins_of(3'b100, 3'b111, 3'b000));
        send_sample(pins_of(3'b011, 3'b011, 3'b111));
        send_sample(pins_of(3'b000, 3'b111, 3'b101));
        send_sample(pins_of(3'b000, 3'b000, 3'b000));
        send_sample(pins_of(3'b111, 3'b111, 3'b111));
        send_sample(pins_of(3'b000, 3'b010, 3'b111));

        levels = pins_of(3'b000, 3'b010, 3'b111);
        for (int n = 0; n < RANDOM_SAMPLES; n++)
            send_sample(next_knob_sample());
        i_valid <= 1'b0;

        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.error_count == 0 && sb.pending_count() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
